// ===== rtl/selective_repeat_sender_window_defines.svh =====
// Assertion macros shared by the sender window RTL.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_DEFINES_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRSW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRSW_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/srsw_pkg.sv =====
// Shared types and constants of the selective-repeat sender window.
// Used by srsw_ctrl, srsw_datapath and the top level; depends on nothing.
package srsw_pkg;

	// Sizing defaults and fixed frame geometry (payload size must be a power of two).
	localparam int MAX_WINDOW_DEF = 16;
	localparam int PAYLOAD_BYTES  = 1024;
	localparam int MAX_FRAMES     = 1024;
	localparam int PAY_SHIFT      = $clog2(PAYLOAD_BYTES);

	// Field and state widths.
	localparam int KIND_W  = 2;
	localparam int BYTES_W = 21;
	localparam int SEQ_W   = 10;
	localparam int OFF_W   = 20;
	localparam int LEN_W   = 11;
	localparam int BASE_W  = 11;
	localparam int TIME_W  = 32;
	localparam int WS_W    = 5;
	localparam int TO_W    = 16;
	localparam int CFGI_W  = 2;
	localparam int CFGD_W  = 16;

	localparam logic [BYTES_W-1:0] BUF_CAP  = BYTES_W'(MAX_FRAMES * PAYLOAD_BYTES);
	localparam logic [BASE_W-1:0]  BASE_MAX = BASE_W'(1 << SEQ_W);
	localparam logic [WS_W-1:0]    WS_RESET = WS_W'(4);
	localparam logic [TO_W-1:0]    TO_RESET = TO_W'(100);

	// Item kinds.
	typedef enum logic [KIND_W-1:0] {
		KIND_START = 2'd0,
		KIND_ACK   = 2'd1,
		KIND_TICK  = 2'd2
	} kind_t;

	// Configuration register indexes.
	typedef enum logic [CFGI_W-1:0] {
		CFG_WINDOW_SIZE   = 2'd0,
		CFG_TIMEOUT_TICKS = 2'd1
	} cfg_idx_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SLIDE,
		ST_SCAN,
		ST_FLUSH,
		ST_STATUS
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic exec_start;
		logic exec_ack;
		logic exec_tick;
		logic slide;
		logic scan_init;
		logic scan_next;
		logic take_slot;
		logic push_held;
		logic push_last;
		logic push_status;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic slide_more;
		logic scan_end;
		logic slot_go;
		logic held_valid;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/selective_repeat_sender_window.sv =====
// Top level of the selective-repeat ARQ sender window.
// Depends on srsw_pkg, srsw_ctrl and srsw_datapath; holds the configuration registers.
//
// Usage:
//   Input channel (in_valid / in_stall): one beat per item, kind selects start of a
//   buffer, acknowledgement or time tick. in_stall is high while an item is in work.
//   Output channel (out_valid / out_stall): one or more beats per item; last marks
//   the final beat of an item. A tick yields one send command per frame due, other
//   items and ticks with nothing to send yield one status beat (send_valid low).
//   Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is always
//   high; index 0 is window_size, index 1 is timeout_ticks; write only between items.
// Sequencing:
//   Start, ack and unknown kinds go through the status state to their status beat. A tick
//   passes through the slide, scan and flush states; the slide drops one acked slot per
//   cycle and the scan visits one slot per cycle through the shared stamp compare, then
//   checks for the end of the window. A stalled output register holds the scan when a
//   second send command is found, and holds the final beat until it drains.
// Reset: window and marks clear, window_size is 4, timeout_ticks is 100.
module selective_repeat_sender_window import srsw_pkg::*; #(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [KIND_W-1:0]  kind,
	input  logic [BYTES_W-1:0] buffer_bytes,
	input  logic               final_buffer,
	input  logic [SEQ_W-1:0]   ack_seq,
	input  logic               ack_negative,
	input  logic               ack_corrupt,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               send_valid,
	output logic [SEQ_W-1:0]   frame_seq,
	output logic [OFF_W-1:0]   payload_offset,
	output logic [LEN_W-1:0]   payload_len,
	output logic               end_of_transfer,
	output logic               buffer_done,
	output logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFGI_W-1:0]  cfg_index,
	input  logic [CFGD_W-1:0]  cfg_data
);

	logic [WS_W-1:0] window_size_q;
	logic [TO_W-1:0] timeout_q;
	cmd_t            cmd;
	sts_t            sts;

	assign cfg_ready = 1'b1;

	// Configuration registers; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WS_RESET;
			timeout_q     <= TO_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_WINDOW_SIZE:   window_size_q <= cfg_data[WS_W-1:0];
				CFG_TIMEOUT_TICKS: timeout_q     <= cfg_data[TO_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer.
	srsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Window state and result path.
	srsw_datapath #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.buffer_bytes    (buffer_bytes),
		.final_buffer    (final_buffer),
		.ack_seq         (ack_seq),
		.ack_negative    (ack_negative),
		.ack_corrupt     (ack_corrupt),
		.window_size     (window_size_q),
		.timeout_ticks   (timeout_q),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.send_valid      (send_valid),
		.frame_seq       (frame_seq),
		.payload_offset  (payload_offset),
		.payload_len     (payload_len),
		.end_of_transfer (end_of_transfer),
		.buffer_done     (buffer_done),
		.last            (last)
	);

endmodule

// ===== rtl/srsw_ctrl.sv =====
// Sequencing state machine of the sender window.
// Depends on srsw_pkg; drives the datapath through cmd_t and reads sts_t.
module srsw_ctrl import srsw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [KIND_W-1:0] kind,
	input  sts_t              sts,
	output cmd_t              cmd
);

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Input items are taken only between items.
	assign in_stall = (state_q != ST_IDLE);

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (kind_t'(kind))
						KIND_START: begin
							cmd.exec_start = 1'b1;
							state_d        = ST_STATUS;
						end
						KIND_ACK: begin
							cmd.exec_ack = 1'b1;
							state_d      = ST_STATUS;
						end
						KIND_TICK: begin
							cmd.exec_tick = 1'b1;
							state_d       = ST_SLIDE;
						end
						default: begin
							state_d = ST_STATUS;
						end
					endcase
				end
			end
			ST_SLIDE: begin
				// Drop one leading acked slot per cycle, then start the scan.
				if (sts.slide_more) begin
					cmd.slide = 1'b1;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// A found frame goes to the holding register; the one it displaces goes out.
				if (sts.scan_end) begin
					state_d = ST_FLUSH;
				end else if (sts.slot_go) begin
					if (!sts.held_valid || sts.out_free) begin
						cmd.take_slot = 1'b1;
						cmd.scan_next = 1'b1;
						cmd.push_held = sts.held_valid;
					end
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			ST_FLUSH: begin
				// The last held frame closes the item; with none, a status beat does.
				if (sts.out_free) begin
					if (sts.held_valid) begin
						cmd.push_held = 1'b1;
						cmd.push_last = 1'b1;
					end else begin
						cmd.push_status = 1'b1;
					end
					state_d = ST_IDLE;
				end
			end
			ST_STATUS: begin
				if (sts.out_free) begin
					cmd.push_status = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/srsw_datapath.sv =====
// Window state, slot marks, send stamps, holding and output registers.
// Depends on srsw_pkg and selective_repeat_sender_window_defines.svh.
`include "selective_repeat_sender_window_defines.svh"

module srsw_datapath import srsw_pkg::*; #(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [BYTES_W-1:0] buffer_bytes,
	input  logic               final_buffer,
	input  logic [SEQ_W-1:0]   ack_seq,
	input  logic               ack_negative,
	input  logic               ack_corrupt,
	input  logic [WS_W-1:0]    window_size,
	input  logic [TO_W-1:0]    timeout_ticks,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               send_valid,
	output logic [SEQ_W-1:0]   frame_seq,
	output logic [OFF_W-1:0]   payload_offset,
	output logic [LEN_W-1:0]   payload_len,
	output logic               end_of_transfer,
	output logic               buffer_done,
	output logic               last
);

	localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W = $clog2(MAX_WINDOW + 1);

	logic [BASE_W-1:0]     base_q;
	logic [BASE_W-1:0]     ftotal_q;
	logic [BYTES_W-1:0]    blen_q;
	logic                  final_q;
	logic [MAX_WINDOW-1:0] acked_q;
	logic [MAX_WINDOW-1:0] sent_q;
	logic [MAX_WINDOW-1:0] resend_q;
	logic [TIME_W-1:0]     stamp_q [MAX_WINDOW];
	logic [TIME_W-1:0]     tick_q;
	logic [CNT_W-1:0]      cnt_q;

	logic                  held_valid_q;
	logic [SEQ_W-1:0]      held_seq_q;
	logic [OFF_W-1:0]      held_off_q;
	logic [LEN_W-1:0]      held_len_q;
	logic                  held_eot_q;

	logic                  out_valid_q;
	logic                  o_send_q;
	logic [SEQ_W-1:0]      o_seq_q;
	logic [OFF_W-1:0]      o_off_q;
	logic [LEN_W-1:0]      o_len_q;
	logic                  o_eot_q;
	logic                  o_done_q;
	logic                  o_last_q;

	logic [CNT_W-1:0]      win;
	logic [IDX_W-1:0]      idx;
	logic [BYTES_W-1:0]    new_len;
	logic [BYTES_W:0]      frame_sum;
	logic [BASE_W-1:0]     ack_diff;
	logic                  ack_hit;
	logic [IDX_W-1:0]      ack_idx;
	logic [BASE_W-1:0]     slot_seq;
	logic [BYTES_W-1:0]    slot_off;
	logic [BYTES_W-1:0]    slot_rem;
	logic [LEN_W-1:0]      slot_len;
	logic                  slot_eot;
	logic [TIME_W-1:0]     elapsed;
	logic                  slot_due;
	logic                  out_free;
	logic                  out_load;

	// Effective window: zero acts as one, large values clamp to the slot count.
	always_comb begin
		if (window_size == '0) begin
			win = CNT_W'(1);
		end else if (int'(window_size) > MAX_WINDOW) begin
			win = CNT_W'(MAX_WINDOW);
		end else begin
			win = CNT_W'(window_size);
		end
	end

	// New buffer length, saturated, and its frame count rounded up.
	assign new_len   = (buffer_bytes > BUF_CAP) ? BUF_CAP : buffer_bytes;
	assign frame_sum = {1'b0, new_len} + (BYTES_W + 1)'(PAYLOAD_BYTES - 1);

	// Acknowledgement window check.
	assign ack_diff = BASE_W'({1'b0, ack_seq}) - base_q;
	assign ack_hit  = !ack_corrupt && (BASE_W'({1'b0, ack_seq}) >= base_q)
	                  && (ack_diff < BASE_W'(win));
	assign ack_idx  = ack_diff[IDX_W-1:0];

	// Slot under the scan pointer.
	assign idx      = cnt_q[IDX_W-1:0];
	assign slot_seq = base_q + BASE_W'(cnt_q);
	assign slot_off = BYTES_W'(slot_seq) * BYTES_W'(PAYLOAD_BYTES);
	assign slot_rem = (blen_q > slot_off) ? (blen_q - slot_off) : '0;
	assign slot_len = (slot_rem < BYTES_W'(PAYLOAD_BYTES)) ? LEN_W'(slot_rem)
	                                                      : LEN_W'(PAYLOAD_BYTES);
	assign slot_eot = final_q && ((slot_seq + BASE_W'(1)) == ftotal_q);
	assign elapsed  = tick_q - stamp_q[idx];
	assign slot_due = !sent_q[idx] || (!acked_q[idx]
	                  && (resend_q[idx] || (elapsed > TIME_W'(timeout_ticks))));

	// Output register can take a beat when empty or being drained.
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = cmd.push_held || cmd.push_status;

	always_comb begin
		sts.slide_more = (cnt_q < win) && acked_q[0];
		sts.scan_end   = (cnt_q >= win);
		sts.slot_go    = (cnt_q < win) && (slot_seq < ftotal_q) && slot_due;
		sts.held_valid = held_valid_q;
		sts.out_free   = out_free;
	end

	// Window base, buffer description and tick counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			ftotal_q <= '0;
			blen_q   <= '0;
			final_q  <= 1'b0;
			tick_q   <= '0;
		end else begin
			if (cmd.exec_start) begin
				base_q   <= '0;
				ftotal_q <= frame_sum[PAY_SHIFT +: BASE_W];
				blen_q   <= new_len;
				final_q  <= final_buffer;
			end
			if (cmd.slide) begin
				base_q <= base_q + BASE_W'(1);
			end
			if (cmd.exec_tick) begin
				tick_q <= tick_q + TIME_W'(1);
			end
		end
	end

	// Slot marks: cleared by a start, set by acks and send commands, shifted one slot per slide step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acked_q  <= '0;
			sent_q   <= '0;
			resend_q <= '0;
		end else begin
			if (cmd.exec_start) begin
				acked_q  <= '0;
				sent_q   <= '0;
				resend_q <= '0;
			end
			if (cmd.exec_ack && ack_hit) begin
				if (ack_negative) begin
					resend_q[ack_idx] <= 1'b1;
				end else begin
					acked_q[ack_idx] <= 1'b1;
				end
			end
			if (cmd.slide) begin
				acked_q  <= acked_q >> 1;
				sent_q   <= sent_q >> 1;
				resend_q <= resend_q >> 1;
			end
			if (cmd.take_slot) begin
				sent_q[idx]   <= 1'b1;
				resend_q[idx] <= 1'b0;
			end
		end
	end

	// Send stamps follow the marks; a stamp is read only under a set sent mark.
	always_ff @(posedge clk) begin
		if (cmd.slide) begin
			for (int k = 0; k < MAX_WINDOW - 1; k++) begin
				stamp_q[k] <= stamp_q[k + 1];
			end
			stamp_q[MAX_WINDOW - 1] <= '0;
		end else if (cmd.take_slot) begin
			stamp_q[idx] <= tick_q;
		end
	end

	// Slide count, then scan pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.exec_tick || cmd.scan_init) begin
			cnt_q <= '0;
		end else if (cmd.slide || cmd.scan_next) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// Holding register: keeps the latest command until it is known whether another follows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
		end else if (cmd.scan_init) begin
			held_valid_q <= 1'b0;
		end else if (cmd.take_slot) begin
			held_valid_q <= 1'b1;
		end else if (cmd.push_held) begin
			held_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_slot) begin
			held_seq_q <= SEQ_W'(slot_seq);
			held_off_q <= OFF_W'(slot_off);
			held_len_q <= slot_len;
			held_eot_q <= slot_eot;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_done_q <= (base_q >= ftotal_q);
			if (cmd.push_held) begin
				o_send_q <= 1'b1;
				o_seq_q  <= held_seq_q;
				o_off_q  <= held_off_q;
				o_len_q  <= held_len_q;
				o_eot_q  <= held_eot_q;
				o_last_q <= cmd.push_last;
			end else begin
				o_send_q <= 1'b0;
				o_seq_q  <= '0;
				o_off_q  <= '0;
				o_len_q  <= '0;
				o_eot_q  <= 1'b0;
				o_last_q <= 1'b1;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign send_valid      = o_send_q;
	assign frame_seq       = o_seq_q;
	assign payload_offset  = o_off_q;
	assign payload_len     = o_len_q;
	assign end_of_transfer = o_eot_q;
	assign buffer_done     = o_done_q;
	assign last            = o_last_q;

	// Consistency checks between controller commands and datapath state.
	`SRSW_ASSERT_NOW(a_push_held_has_data, cmd.push_held, held_valid_q, "push of empty holding register")
	`SRSW_ASSERT_NOW(a_load_when_free, out_load, out_free, "output register overwritten while stalled")
	`SRSW_ASSERT_NOW(a_take_in_buffer, cmd.take_slot, slot_seq < ftotal_q, "send command past buffer end")
	`SRSW_ASSERT_NXT(a_take_marks_sent, cmd.take_slot, sent_q[$past(idx)], "sent mark not set after send")
	`SRSW_ASSERT_NOW(a_base_bound, 1'b1, base_q <= BASE_MAX, "window base beyond sequence space")

endmodule

// ===== dv/selective_repeat_sender_window_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the selective-repeat sender window: mirrors the window state and predicts beats.
// Watches the item, result and register channels; depends on srsw_pkg only.
module selective_repeat_sender_window_checker
	import srsw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [KIND_W-1:0]  kind,
	input  logic [BYTES_W-1:0] buffer_bytes,
	input  logic               final_buffer,
	input  logic [SEQ_W-1:0]   ack_seq,
	input  logic               ack_negative,
	input  logic               ack_corrupt,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               send_valid,
	input  logic [SEQ_W-1:0]   frame_seq,
	input  logic [OFF_W-1:0]   payload_offset,
	input  logic [LEN_W-1:0]   payload_len,
	input  logic               end_of_transfer,
	input  logic               buffer_done,
	input  logic               last,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [CFGI_W-1:0]  cfg_index,
	input  logic [CFGD_W-1:0]  cfg_data,
	output int                 mismatches,
	output int                 outstanding,
	output int                 beats_seen,
	output int                 sends_seen,
	output int                 done_seen
);

	localparam int SLOTS      = MAX_WINDOW_DEF;
	localparam int REPORT_MAX = 10;

	// One result beat as the block presents it.
	typedef struct packed {
		logic             send;
		logic [SEQ_W-1:0] seq;
		logic [OFF_W-1:0] off;
		logic [LEN_W-1:0] len;
		logic             eot;
		logic             done;
		logic             last;
	} frame_cmd_t;

	frame_cmd_t cmd_due[$];
	frame_cmd_t seen_beat;
	frame_cmd_t want_beat;

	// Mirror of the register file and of the window.
	logic [WS_W-1:0]   win_cfg;
	logic [TO_W-1:0]   timeout_cfg;
	int unsigned       base_seq;
	int unsigned       frame_cnt;
	int unsigned       buf_len;
	logic              final_flag;
	logic [SLOTS-1:0]  acked;
	logic [SLOTS-1:0]  sent;
	logic [SLOTS-1:0]  resend;
	logic [TIME_W-1:0] stamp [SLOTS];
	logic [TIME_W-1:0] tick_now;

	// Number of slots in play, with out-of-range settings clamped.
	function automatic int unsigned live_span();
		int unsigned w;
		w = win_cfg;
		if (w < 1) w = 1;
		if (w > SLOTS) w = SLOTS;
		return w;
	endfunction

	// Status beat that closes every item without a send.
	function automatic frame_cmd_t status_beat();
		frame_cmd_t r;
		r = '0;
		r.done = (base_seq >= frame_cnt);
		r.last = 1'b1;
		return r;
	endfunction

	// Apply one accepted item to the mirror and queue the beats it must produce.
	task automatic predict(input logic [KIND_W-1:0] k, input logic [BYTES_W-1:0] bytes,
			input logic fin, input logic [SEQ_W-1:0] seq_in, input logic neg,
			input logic bad);
		int unsigned w;
		int unsigned shift;
		int unsigned clip;
		int unsigned seq;
		int unsigned off;
		int unsigned rem;
		int unsigned src;
		int n;
		logic [TIME_W-1:0] age;
		frame_cmd_t c;
		w = live_span();
		n = 0;
		case (k)
			KIND_START: begin
				clip = (bytes > BUF_CAP) ? BUF_CAP : bytes;
				buf_len = clip;
				frame_cnt = (clip + PAYLOAD_BYTES - 1) / PAYLOAD_BYTES;
				final_flag = fin;
				base_seq = 0;
				acked = '0;
				sent = '0;
				resend = '0;
			end
			KIND_ACK: begin
				if (!bad && seq_in >= base_seq && seq_in - base_seq < w) begin
					if (neg) resend[seq_in - base_seq] = 1'b1;
					else acked[seq_in - base_seq] = 1'b1;
				end
			end
			KIND_TICK: begin
				tick_now = tick_now + 1'b1;
				// Slide past the run of acknowledged slots at the front.
				shift = 0;
				while (shift < w && acked[shift]) shift++;
				if (shift > 0) begin
					for (int i = 0; i < SLOTS; i++) begin
						src = i + shift;
						if (src < SLOTS) begin
							acked[i] = acked[src];
							sent[i] = sent[src];
							resend[i] = resend[src];
							stamp[i] = stamp[src];
						end else begin
							acked[i] = 1'b0;
							sent[i] = 1'b0;
							resend[i] = 1'b0;
							stamp[i] = '0;
						end
					end
					base_seq += shift;
				end
				// Scan the window for frames that are new, nacked or timed out.
				for (int i = 0; i < w; i++) begin
					seq = base_seq + i;
					if (seq >= frame_cnt) continue;
					age = tick_now - stamp[i];
					if (!sent[i] || (!acked[i] && (resend[i] || age > timeout_cfg))) begin
						off = seq * PAYLOAD_BYTES;
						rem = (buf_len > off) ? buf_len - off : 0;
						c = '0;
						c.send = 1'b1;
						c.seq = seq[SEQ_W-1:0];
						c.off = off[OFF_W-1:0];
						c.len = (rem < PAYLOAD_BYTES) ? rem[LEN_W-1:0] : LEN_W'(PAYLOAD_BYTES);
						c.eot = final_flag && (seq + 1 == frame_cnt);
						c.done = (base_seq >= frame_cnt);
						cmd_due.push_back(c);
						n++;
						sent[i] = 1'b1;
						stamp[i] = tick_now;
						resend[i] = 1'b0;
					end
				end
				if (n > 0) cmd_due[cmd_due.size() - 1].last = 1'b1;
			end
			default: ;
		endcase
		if (n == 0) cmd_due.push_back(status_beat());
	endtask

	// Register writes, result checks and item predictions, in that order per edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_cfg = WS_RESET;
			timeout_cfg = TO_RESET;
			base_seq = 0;
			frame_cnt = 0;
			buf_len = 0;
			final_flag = 1'b0;
			acked = '0;
			sent = '0;
			resend = '0;
			for (int i = 0; i < SLOTS; i++) stamp[i] = '0;
			tick_now = '0;
			cmd_due.delete();
			mismatches = 0;
			outstanding = 0;
			beats_seen = 0;
			sends_seen = 0;
			done_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_WINDOW_SIZE:   win_cfg = cfg_data[WS_W-1:0];
					CFG_TIMEOUT_TICKS: timeout_cfg = cfg_data[TO_W-1:0];
					default: ;
				endcase
			end

			// Compare each accepted beat with the oldest prediction.
			if (out_valid && !out_stall) begin
				seen_beat = {send_valid, frame_seq, payload_offset, payload_len,
					end_of_transfer, buffer_done, last};
				beats_seen++;
				if (send_valid) sends_seen++;
				if (buffer_done) done_seen++;
				if (cmd_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("ERROR: unexpected beat send=%0b seq=%0d last=%0b at %0t",
							send_valid, frame_seq, last, $time);
				end else begin
					want_beat = cmd_due.pop_front();
					if (seen_beat !== want_beat) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("ERROR: beat %0d expected send=%0b seq=%0d off=%0d ",
								beats_seen, want_beat.send, want_beat.seq, want_beat.off,
								"len=%0d eot=%0b done=%0b last=%0b, ", want_beat.len,
								want_beat.eot, want_beat.done, want_beat.last,
								"got send=%0b seq=%0d off=%0d len=%0d ", seen_beat.send,
								seen_beat.seq, seen_beat.off, seen_beat.len,
								"eot=%0b done=%0b last=%0b", seen_beat.eot, seen_beat.done,
								seen_beat.last);
					end
				end
			end

			if (in_valid && !in_stall)
				predict(kind, buffer_bytes, final_buffer, ack_seq, ack_negative, ack_corrupt);
			outstanding = cmd_due.size();
		end
	end

endmodule

// ===== dv/selective_repeat_sender_window_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the selective-repeat sender window: clock, reset, stimulus and verdict.
// Depends on srsw_pkg, the block and selective_repeat_sender_window_checker.
module selective_repeat_sender_window_tb import srsw_pkg::*; ();

	localparam int HOLD_CYCLES = 300;
	localparam int STUCK_LIMIT = 3000;
	localparam int END_WAIT    = 60;
	localparam int BYTES_MAX   = (1 << BYTES_W) - 1;
	localparam int SEQ_MAX     = (1 << SEQ_W) - 1;
	localparam int SEQ_SPACE   = 2048;
	localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [KIND_W-1:0]  kind = KIND_START;
	logic [BYTES_W-1:0] buffer_bytes = '0;
	logic               final_buffer = 1'b0;
	logic [SEQ_W-1:0]   ack_seq = '0;
	logic               ack_negative = 1'b0;
	logic               ack_corrupt = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               send_valid;
	logic [SEQ_W-1:0]   frame_seq;
	logic [OFF_W-1:0]   payload_offset;
	logic [LEN_W-1:0]   payload_len;
	logic               end_of_transfer;
	logic               buffer_done;
	logic               last;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CFGI_W-1:0]  cfg_index = CFG_WINDOW_SIZE;
	logic [CFGD_W-1:0]  cfg_data = '0;

	int mismatches;
	int outstanding;
	int beats_seen;
	int sends_seen;
	int done_seen;

	// Stimulus bookkeeping: where the window should stand, for well-formed acks.
	bit          calm = 1'b0;
	int          hold_asks = 0;
	int          kind_count [4] = '{default: 0};
	int          item_total = 0;
	int          settings = 0;
	int unsigned span = WS_RESET;
	int unsigned win_base = 0;
	int unsigned frame_goal = 0;
	bit          acked_seq [SEQ_SPACE];

	selective_repeat_sender_window u_dut (.*);

	selective_repeat_sender_window_checker u_checker (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	// Offer one item and hold it until the block takes it; sometimes idle afterward.
	task automatic put_item(input logic [KIND_W-1:0] k, input logic [BYTES_W-1:0] bytes,
			input logic fin, input logic [SEQ_W-1:0] seq, input logic neg, input logic bad);
		in_valid <= 1'b1;
		kind <= k;
		buffer_bytes <= bytes;
		final_buffer <= fin;
		ack_seq <= seq;
		ack_negative <= neg;
		ack_corrupt <= bad;
		do @(posedge clk); while (in_stall);
		kind_count[k]++;
		item_total++;
		if (!calm && $urandom_range(0, 99) < 10) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic send_ack(input int unsigned seq, input logic neg, input logic bad);
		put_item(KIND_ACK, BYTES_W'($urandom_range(0, BYTES_MAX)), 1'($urandom_range(0, 1)),
			seq[SEQ_W-1:0], neg, bad);
	endtask

	// A start resets the window, so the bookkeeping restarts too.
	task automatic start_buffer(input int unsigned bytes, input logic fin);
		int unsigned clip;
		put_item(KIND_START, bytes[BYTES_W-1:0], fin, SEQ_W'($urandom_range(0, SEQ_MAX)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		clip = (bytes > BUF_CAP) ? BUF_CAP : bytes;
		frame_goal = (clip + PAYLOAD_BYTES - 1) / PAYLOAD_BYTES;
		win_base = 0;
		acked_seq = '{default: 1'b0};
	endtask

	// A tick slides the window past the acked run at its front.
	task automatic tick_item();
		int unsigned shift;
		put_item(KIND_TICK, BYTES_W'($urandom_range(0, BYTES_MAX)), 1'($urandom_range(0, 1)),
			SEQ_W'($urandom_range(0, SEQ_MAX)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
		shift = 0;
		while (shift < span && acked_seq[win_base + shift]) shift++;
		win_base += shift;
	endtask

	// Mostly useful acks inside the window, with nacks, corrupt and stray ones mixed in.
	task automatic ack_item();
		int unsigned pick;
		int unsigned k;
		int unsigned seq;
		logic neg;
		logic bad;
		pick = $urandom_range(0, 99);
		neg = 1'b0;
		bad = 1'b0;
		if (pick < 70) begin
			k = 0;
			if (pick < 45) begin
				while (k < span - 1 && acked_seq[win_base + k]) k++;
			end else begin
				k = $urandom_range(0, span - 1);
			end
			seq = win_base + k;
		end else if (pick < 80) begin
			seq = win_base + $urandom_range(0, span - 1);
			neg = 1'b1;
		end else if (pick < 90) begin
			seq = $urandom_range(0, SEQ_MAX);
			neg = 1'($urandom_range(0, 1));
			bad = 1'b1;
		end else begin
			seq = $urandom_range(0, SEQ_MAX);
			neg = 1'($urandom_range(0, 1));
			if (!neg && seq >= win_base && seq < win_base + span) bad = 1'b1;
		end
		if (seq > SEQ_MAX) begin
			seq = $urandom_range(0, SEQ_MAX);
			bad = 1'b1;
		end
		if (pick < 70 && !bad) acked_seq[seq] = 1'b1;
		send_ack(seq, neg, bad);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// Register write; the caller lowers the valid after its last write.
	task automatic write_reg(input cfg_idx_t idx, input logic [CFGD_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// One setting of the registers followed by random transfers and noise.
	task automatic run_phase(input logic [WS_W-1:0] ws, input logic [TO_W-1:0] timeout,
			input int budget, input bit quiet, input bit squeeze);
		int first;
		int rounds;
		int unsigned bytes;
		bit held;
		logic [KIND_W-1:0] k;
		wait_drained();
		write_reg(CFG_WINDOW_SIZE,
			{(CFGD_W - WS_W)'($urandom_range(0, (1 << (CFGD_W - WS_W)) - 1)), ws});
		write_reg(CFG_TIMEOUT_TICKS, timeout);
		cfg_valid <= 1'b0;
		settings++;
		span = (ws < 1) ? 1 : (ws > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : ws;
		calm <= quiet;
		first = item_total;
		held = 1'b0;
		while (item_total - first < budget) begin
			if ($urandom_range(0, 99) < 15) begin
				// Noise: stray acks, ticks and reserved kinds with random content.
				repeat ($urandom_range(1, 3)) begin
					k = KIND_W'($urandom_range(KIND_ACK, KIND_RESERVED));
					put_item(k, BYTES_W'($urandom_range(0, BYTES_MAX)),
						1'($urandom_range(0, 1)), SEQ_W'($urandom_range(0, SEQ_MAX)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end
			end else begin
				// Mostly short buffers, now and then one of any size.
				if ($urandom_range(0, 19) == 0) bytes = $urandom_range(0, BYTES_MAX);
				else bytes = $urandom_range(0, 10 * PAYLOAD_BYTES);
				start_buffer(bytes, 1'($urandom_range(0, 1)));
				if (squeeze && !held) begin
					hold_asks <= hold_asks + 1;
					held = 1'b1;
				end
				rounds = 0;
				while (win_base < frame_goal && rounds < 10 && item_total - first < budget) begin
					tick_item();
					repeat ($urandom_range(1, (span < 4) ? span + 1 : 5)) ack_item();
					rounds++;
				end
				tick_item();
			end
		end
	endtask

	// Result side: random stalls, and a long hold-off whenever one is asked for.
	initial begin : receiver
		int hold_left;
		int hold_served;
		hold_left = 0;
		hold_served = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_asks != hold_served) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 10);
			end
		end
	end

	// Give up once nothing has moved on any channel for too long.
	initial begin : watchdog
		int stuck;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				stuck = 0;
			else
				stuck++;
		end
		$display("ERROR: no beat accepted for %0d cycles", STUCK_LIMIT);
		$display("FAIL selective_repeat_sender_window");
		$finish;
	end

	initial begin : stimulus
		acked_seq = '{default: 1'b0};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset settings: four slots, timeout of 100 ticks.
		put_item(KIND_RESERVED, BYTES_W'(BYTES_MAX), 1'b1, SEQ_W'(SEQ_MAX), 1'b1, 1'b1);
		start_buffer(0, 1'b1);
		tick_item();
		// Oversized buffer saturates; nack, corrupt and out-of-window acks.
		start_buffer(BYTES_MAX, 1'b1);
		tick_item();
		send_ack(3, 1'b0, 1'b0);
		send_ack(2, 1'b1, 1'b0);
		send_ack(1, 1'b0, 1'b1);
		send_ack(SEQ_MAX, 1'b0, 1'b0);
		tick_item();
		send_ack(0, 1'b0, 1'b0);
		tick_item();
		// A nack on an acked slot must not cause a resend.
		send_ack(3, 1'b1, 1'b0);
		tick_item();
		// Short last frame, end of transfer, and an ack past the last frame.
		start_buffer(2500, 1'b1);
		tick_item();
		send_ack(0, 1'b0, 1'b0);
		send_ack(1, 1'b0, 1'b0);
		send_ack(2, 1'b0, 1'b0);
		send_ack(3, 1'b0, 1'b0);
		tick_item();
		start_buffer(1, 1'b0);
		tick_item();
		send_ack(0, 1'b0, 1'b0);
		tick_item();
		start_buffer(BUF_CAP, 1'b0);

		// Random part across settings, the extremes among them.
		run_phase(5'd1, 16'd5, 30, 1'b0, 1'b0);
		run_phase(5'd16, 16'd0, 30, 1'b0, 1'b1);
		run_phase(5'd31, 16'd3, 30, 1'b1, 1'b0);
		run_phase(5'd0, 16'd65535, 25, 1'b0, 1'b0);
		run_phase(5'd8, 16'd1, 30, 1'b0, 1'b0);
		run_phase(5'd3, 16'd12, 30, 1'b0, 1'b0);
		run_phase(5'd4, 16'd100, 30, 1'b0, 1'b0);

		wait_drained();
		repeat (END_WAIT) @(posedge clk);

		$display("Covered %0d starts, %0d acks, %0d ticks, %0d reserved items over %0d settings.",
			kind_count[KIND_START], kind_count[KIND_ACK], kind_count[KIND_TICK],
			kind_count[KIND_RESERVED], settings + 1);
		$display("Checked %0d result beats: %0d send commands, %0d with the buffer complete.",
			beats_seen, sends_seen, done_seen);
		if (mismatches == 0 && outstanding == 0) begin
			$display("PASS selective_repeat_sender_window");
		end else begin
			$display("ERROR: %0d mismatches, %0d beats never seen", mismatches, outstanding);
			$display("FAIL selective_repeat_sender_window");
		end
		$finish;
	end

endmodule
